// File: src/ptar_pkg.sv
// ----------------------------------------------------------------------------
// ptar_pkg
// Shared types and constants of the page table address router: item payloads,
// function codes, page table entry layout and the memory command bundle.
// ----------------------------------------------------------------------------
package ptar_pkg;

	// Default table depth and fixed limits
	localparam int PAGE_COUNT_DEF = 256;
	localparam int HANDLER_SLOTS  = 32;
	localparam int PAGE_SHIFT     = 24;
	localparam int PAGE_IDX_W     = 8;

	// Function codes of an input item
	typedef enum logic [2:0] {
		FN_READ        = 3'd0,
		FN_WRITE       = 3'd1,
		FN_MAP_HANDLER = 3'd2,
		FN_MAP_BLOCK   = 3'd3,
		FN_MIRROR      = 3'd4
	} func_t;

	// Size codes
	localparam logic [1:0] SIZE_WORD  = 2'd2;
	localparam logic [1:0] SIZE_DWORD = 2'd3;

	// Input item
	typedef struct packed {
		logic [2:0]  func;
		logic [31:0] addr;
		logic [1:0]  size_code;
		logic [63:0] wdata;
		logic [4:0]  handler_sel;
		logic [2:0]  region_sel;
		logic [31:0] region_mask;
		logic [7:0]  first_page;
		logic [7:0]  last_page;
		logic [7:0]  dest_page;
		logic [8:0]  page_count;
	} req_t;

	// Result item
	typedef struct packed {
		logic        to_memory;
		logic [4:0]  target_id;
		logic [31:0] route_addr;
		logic        is_write;
		logic [1:0]  out_size;
		logic [63:0] out_data;
		logic        last;
	} rsp_t;

	// Page table entry: memory flag, handler or region id, offset shift 0..32
	typedef struct packed {
		logic       mem;
		logic [4:0] id;
		logic [5:0] shift;
	} page_entry_t;

	// Table access bundle, one write and one read port
	typedef struct packed {
		logic                  we;
		logic [PAGE_IDX_W-1:0] waddr;
		page_entry_t           wentry;
		logic                  re;
		logic [PAGE_IDX_W-1:0] raddr;
	} mem_cmd_t;

	// Leading zero counter result
	typedef struct packed {
		logic       done;
		logic [5:0] count;
	} lzc_res_t;

endpackage

// File: src/ptar_chan_if.sv
// ----------------------------------------------------------------------------
// ptar_chan_if
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface ptar_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// File: src/ptar_page_mem.sv
// ----------------------------------------------------------------------------
// ptar_page_mem
// Page table storage: synchronous memory with one write and one registered
// read port; per-entry valid bits make untouched entries read as handler 0.
// ----------------------------------------------------------------------------
module ptar_page_mem import ptar_pkg::*; #(
	parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  mem_cmd_t    cmd,
	output page_entry_t rd_entry
);
	localparam int PW = $clog2(PAGE_COUNT);

	page_entry_t            mem_q [PAGE_COUNT];
	logic [PAGE_COUNT-1:0]  valid_q;
	page_entry_t            rdata_s1;
	logic                   rvalid_s1;

	// Storage array, write and registered read
	always_ff @(posedge clk) begin
		if (cmd.we) begin
			mem_q[cmd.waddr[PW-1:0]] <= cmd.wentry;
		end
		if (cmd.re) begin
			rdata_s1 <= mem_q[cmd.raddr[PW-1:0]];
		end
	end

	// Valid bits, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rvalid_s1 <= 1'b0;
		end else begin
			if (cmd.we) begin
				valid_q[cmd.waddr[PW-1:0]] <= 1'b1;
			end
			if (cmd.re) begin
				rvalid_s1 <= valid_q[cmd.raddr[PW-1:0]];
			end
		end
	end

	assign rd_entry = rvalid_s1 ? rdata_s1 : '0;

	// Sequencer never reads and writes the table in the same cycle
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.we && cmd.re))
		else $error("table read and write in the same cycle");

endmodule

// File: src/ptar_lzc.sv
// ----------------------------------------------------------------------------
// ptar_lzc
// Iterative leading zero counter over a 32-bit mask, one byte per cycle.
// ----------------------------------------------------------------------------
module ptar_lzc import ptar_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] mask,
	output lzc_res_t    res
);
	logic [31:0] word_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [7:0]  top_byte;
	logic        hit;
	logic        last_byte;

	// Leading zeros of a nonzero byte
	function automatic logic [2:0] lz8(input logic [7:0] b);
		logic [2:0] n;
		logic       seen;
		n    = '0;
		seen = 1'b0;
		for (int i = 7; i >= 0; i--) begin
			if (!seen) begin
				if (b[i]) seen = 1'b1;
				else      n    = n + 3'd1;
			end
		end
		return n;
	endfunction

	assign top_byte  = word_q[31:24];
	assign hit       = (top_byte != 8'd0);
	assign last_byte = (cnt_q == 6'd24);

	assign res.done  = busy_q && (hit || last_byte);
	assign res.count = hit ? (cnt_q + 6'(lz8(top_byte))) : 6'd32;

	// Scan from the top byte down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			word_q <= '0;
		end else if (start && !busy_q) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
			word_q <= mask;
		end else if (busy_q) begin
			if (hit || last_byte) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q  <= cnt_q + 6'd8;
				word_q <= {word_q[23:0], 8'd0};
			end
		end
	end

	// Count never runs past the last byte
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= 6'd24))
		else $error("leading zero scan ran past last byte");

endmodule

// File: src/page_table_address_router.sv
// ----------------------------------------------------------------------------
// page_table_address_router
// Routes bus accesses through a page table indexed by the top address byte
// and services map and mirror items that rewrite the table.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one item per valid/ready handshake; rsp returns route results.
//   Read and write items give one result (two for an 8-byte handler access,
//   low half first, last set on the second). Map and mirror items give none.
//   The registered table read puts an access result in the output register
//   from the access state, and the high half of a split access from the
//   split state; a new item is accepted only once the sequencer is back
//   in idle. A handler map writes its pages one by one; a block map first
//   runs the byte-serial leading zero count of the mask. A mirror reads
//   then writes back each page through the single table port pair.
//   req.ready is high only while the sequencer is idle.
//   A result sits in a one-item output register; a stalled receiver holds the
//   sequencer in its output state while an already accepted item waits there.
//   Reset: asynchronous, active low. Every entry reads as handler 0 right after
//   reset through per-entry valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module page_table_address_router import ptar_pkg::*; #(
	parameter int PAGE_COUNT = PAGE_COUNT_DEF
) (
	input logic         clk,
	input logic         arst_n,
	ptar_chan_if.sink   req,
	ptar_chan_if.source rsp
);
	localparam int PW    = $clog2(PAGE_COUNT);
	localparam int CW    = $clog2(PAGE_COUNT + 1);
	localparam int RECIP = (65536 + PAGE_COUNT - 1) / PAGE_COUNT;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ACC   = 7'b0000010,
		S_SPLIT = 7'b0000100,
		S_LZC   = 7'b0001000,
		S_FILL  = 7'b0010000,
		S_CP_RD = 7'b0100000,
		S_CP_WR = 7'b1000000
	} state_t;

	state_t      state_q;
	logic [PW-1:0] ptr_q, end_q, src_q, dst_q;
	logic [CW-1:0] cnt_q;
	page_entry_t new_q;
	logic [31:0] addr_q;
	logic [1:0]  size_q;
	logic        wr_q;
	logic [63:0] data_q;
	rsp_t        rsp_q;
	logic        rsp_valid_q;

	mem_cmd_t    cmd;
	page_entry_t rd_entry;
	lzc_res_t    lzc_res;
	logic        accept;
	logic        slot_free;
	logic        rsp_load;
	logic        lzc_start;
	logic [PW-1:0] page_a, page_b, page_d, page_acc;
	logic        range_ok;
	logic [CW-1:0] mir_cnt;
	logic [31:0] offset;

	// Page number modulo table depth by reciprocal multiply
	function automatic logic [PW-1:0] page_mod(input logic [7:0] v);
		logic [23:0] prod;
		logic [15:0] rem;
		prod = 24'(v) * 24'(RECIP);
		rem  = 16'(v) - 16'(prod[23:16]) * 16'(PAGE_COUNT);
		return rem[PW-1:0];
	endfunction

	function automatic logic [PW-1:0] page_inc(input logic [PW-1:0] p);
		return (p == PW'(PAGE_COUNT - 1)) ? '0 : p + PW'(1);
	endfunction

	assign accept    = req.valid && req.ready;
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign rsp_load  = slot_free && ((state_q == S_ACC) || (state_q == S_SPLIT));

	assign req.ready   = (state_q == S_IDLE);
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// Decoded page numbers of the incoming item
	assign page_a   = page_mod(req.payload.first_page);
	assign page_b   = page_mod(req.payload.last_page);
	assign page_d   = page_mod(req.payload.dest_page);
	assign page_acc = page_mod(req.payload.addr[31:PAGE_SHIFT]);
	assign range_ok = (page_a <= page_b);
	assign mir_cnt  = (req.payload.page_count > 9'(PAGE_COUNT)) ? CW'(PAGE_COUNT)
	                                                            : CW'(req.payload.page_count);

	assign lzc_start = accept && (req.payload.func == FN_MAP_BLOCK) && range_ok;

	// Memory offset of a region access
	assign offset = (rd_entry.shift >= 6'd32) ? 32'd0
	                                          : (addr_q & (32'hFFFF_FFFF >> rd_entry.shift));

	// Table port commands
	always_comb begin
		cmd        = '0;
		cmd.wentry = new_q;
		if (accept && ((req.payload.func == FN_READ) || (req.payload.func == FN_WRITE))) begin
			cmd.re    = 1'b1;
			cmd.raddr = PAGE_IDX_W'(page_acc);
		end
		if (state_q == S_CP_RD) begin
			cmd.re    = 1'b1;
			cmd.raddr = PAGE_IDX_W'(src_q);
		end
		if (state_q == S_FILL) begin
			cmd.we    = 1'b1;
			cmd.waddr = PAGE_IDX_W'(ptr_q);
		end
		if (state_q == S_CP_WR) begin
			cmd.we     = 1'b1;
			cmd.waddr  = PAGE_IDX_W'(dst_q);
			cmd.wentry = rd_entry;
		end
	end

	ptar_page_mem #(
		.PAGE_COUNT (PAGE_COUNT)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.rd_entry (rd_entry)
	);

	ptar_lzc u_lzc (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (lzc_start),
		.mask   (req.payload.region_mask),
		.res    (lzc_res)
	);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ptr_q       <= '0;
			end_q       <= '0;
			src_q       <= '0;
			dst_q       <= '0;
			cnt_q       <= '0;
			new_q       <= '0;
			addr_q      <= '0;
			size_q      <= '0;
			wr_q        <= 1'b0;
			data_q      <= '0;
			rsp_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.payload.func)
							FN_READ, FN_WRITE: begin
								addr_q  <= req.payload.addr;
								size_q  <= req.payload.size_code;
								wr_q    <= (req.payload.func == FN_WRITE);
								data_q  <= (req.payload.func == FN_WRITE) ? req.payload.wdata
								                                          : 64'd0;
								state_q <= S_ACC;
							end
							FN_MAP_HANDLER: begin
								if (range_ok && ({1'b0, req.payload.handler_sel}
								                 < 6'(HANDLER_SLOTS))) begin
									ptr_q   <= page_a;
									end_q   <= page_b;
									new_q   <= '{mem: 1'b0, id: req.payload.handler_sel,
									             shift: 6'd0};
									state_q <= S_FILL;
								end
							end
							FN_MAP_BLOCK: begin
								if (range_ok) begin
									ptr_q   <= page_a;
									end_q   <= page_b;
									new_q   <= '{mem: 1'b1, id: {2'b00, req.payload.region_sel},
									             shift: 6'd0};
									state_q <= S_LZC;
								end
							end
							FN_MIRROR: begin
								if (mir_cnt != '0) begin
									src_q   <= page_a;
									dst_q   <= page_d;
									cnt_q   <= mir_cnt;
									state_q <= S_CP_RD;
								end
							end
							default: ;
						endcase
					end
				end
				S_ACC: begin
					if (slot_free) begin
						rsp_q.target_id   <= rd_entry.id;
						rsp_q.is_write    <= wr_q;
						if (rd_entry.mem) begin
							rsp_q.to_memory  <= 1'b1;
							rsp_q.route_addr <= offset;
							rsp_q.out_size   <= size_q;
							rsp_q.out_data   <= data_q;
							rsp_q.last       <= 1'b1;
							state_q          <= S_IDLE;
						end else if (size_q == SIZE_DWORD) begin
							rsp_q.to_memory  <= 1'b0;
							rsp_q.route_addr <= addr_q;
							rsp_q.out_size   <= SIZE_WORD;
							rsp_q.out_data   <= {32'd0, data_q[31:0]};
							rsp_q.last       <= 1'b0;
							state_q          <= S_SPLIT;
						end else begin
							rsp_q.to_memory  <= 1'b0;
							rsp_q.route_addr <= addr_q;
							rsp_q.out_size   <= size_q;
							rsp_q.out_data   <= data_q;
							rsp_q.last       <= 1'b1;
							state_q          <= S_IDLE;
						end
					end
				end
				S_SPLIT: begin
					// High half of an 8-byte handler access
					if (slot_free) begin
						rsp_q.route_addr <= addr_q + 32'd4;
						rsp_q.out_data   <= {32'd0, data_q[63:32]};
						rsp_q.last       <= 1'b1;
						state_q          <= S_IDLE;
					end
				end
				S_LZC: begin
					if (lzc_res.done) begin
						new_q.shift <= lzc_res.count;
						state_q     <= S_FILL;
					end
				end
				S_FILL: begin
					if (ptr_q == end_q) begin
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + PW'(1);
					end
				end
				S_CP_RD: begin
					state_q <= S_CP_WR;
				end
				S_CP_WR: begin
					src_q <= page_inc(src_q);
					dst_q <= page_inc(dst_q);
					cnt_q <= cnt_q - CW'(1);
					state_q <= (cnt_q == CW'(1)) ? S_IDLE : S_CP_RD;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Range fill never passes its end page
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (ptr_q <= end_q))
		else $error("range fill past end page");

	// Region results are never split
	a_mem_single: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.payload.to_memory) |-> rsp.payload.last)
		else $error("memory route result not marked last");

	// First half of a split leaves only while its second half is pending
	a_split_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.ready && !rsp.payload.last) |-> (state_q == S_SPLIT))
		else $error("split result without pending high half");

	// Mirror copy always has pages left while active
	a_copy_count: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_CP_RD) || (state_q == S_CP_WR)) |-> (cnt_q != '0))
		else $error("mirror copy running with zero count");

endmodule
